FILE: rtl/particle_euler_integrate_damp_defines.svh
// Assertion macros for the particle integrator checker.
// No dependencies; the checker file includes this header.
`ifndef PARTICLE_EULER_INTEGRATE_DAMP_DEFINES_SVH
`define PARTICLE_EULER_INTEGRATE_DAMP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define PEI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pei check failed");

// Next-cycle implication, sampled on i_clk and off while i_rst_n is low.
`define PEI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pei check failed");

`endif

FILE: rtl/pei_pkg.sv
// Shared types, constants and helpers for the particle integrator.
// No dependencies; every module file imports this package.
package pei_pkg;

    localparam int DATA_W            = 32;
    localparam int DT_W              = 17;
    localparam int IDT_W             = 27;
    localparam int AXES              = 3;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_W         = 3;

    localparam logic [DT_W-1:0]          TIME_STEP_RST = 17'd1092;
    localparam logic [IDT_W-1:0]         INV_STEP_RST  = 27'd3932160;
    localparam logic signed [DATA_W-1:0] GRAV_X_RST    = 32'sd0;
    localparam logic signed [DATA_W-1:0] GRAV_Y_RST    = 32'sd0;
    localparam logic signed [DATA_W-1:0] GRAV_Z_RST    = 32'shFFF630A4;
    localparam logic [DATA_W-1:0]        DAMP_RATE_RST = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP     = 3'd0,
        REG_INV_TIME_STEP = 3'd1,
        REG_GRAVITY_X     = 3'd2,
        REG_GRAVITY_Y     = 3'd3,
        REG_GRAVITY_Z     = 3'd4,
        REG_DAMPING_RATE  = 3'd5
    } t_reg_idx;

    typedef enum logic {
        KIND_PRE  = 1'b0,
        KIND_POST = 1'b1
    } t_kind;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] previous_x;
        logic signed [31:0] previous_y;
        logic signed [31:0] previous_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic        [31:0] inverse_mass;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_position_x;
        logic signed [31:0] new_position_y;
        logic signed [31:0] new_position_z;
        logic signed [31:0] new_previous_x;
        logic signed [31:0] new_previous_y;
        logic signed [31:0] new_previous_z;
        logic signed [31:0] new_velocity_x;
        logic signed [31:0] new_velocity_y;
        logic signed [31:0] new_velocity_z;
    } t_out_item;

    // Stage load enables shared by the lanes and the damping factor unit.
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en4;
    } t_stage_ctl;

    // What one axis lane hands to the merge stage.
    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] prev;
        logic signed [31:0] vel;
        logic signed [31:0] calc_pos;
        logic signed [31:0] calc_vel;
    } t_lane_res;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh000000007FFFFFFF;
        lo = 64'shFFFFFFFF80000000;
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

FILE: rtl/pei_lane.sv
// One axis of the integrator: two multiply stages, each followed by round and saturate.
// Depends on pei_pkg.
module pei_lane import pei_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  t_stage_ctl                i_ctl,
    input  logic                      i_kind,
    input  logic signed [31:0]        i_pos,
    input  logic signed [31:0]        i_prev,
    input  logic signed [31:0]        i_vel,
    input  logic signed [31:0]        i_grav,
    input  logic [DT_W-1:0]           i_dt,
    input  logic [IDT_W-1:0]          i_idt,
    input  logic [FRACTION_BITS:0]    i_factor,
    output t_lane_res                 o_res
);

    localparam int A1_W = DATA_W + 1;
    localparam int B1_W = IDT_W + 1;
    localparam int P1_W = A1_W + B1_W;
    localparam int MB_W = (DT_W > FRACTION_BITS + 1) ? DT_W : FRACTION_BITS + 1;
    localparam int B3_W = MB_W + 1;
    localparam int P3_W = DATA_W + B3_W;
    localparam logic signed [P1_W-1:0] HALF1 = P1_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [P3_W-1:0] HALF3 = P3_W'(1) <<< (FRACTION_BITS - 1);

    logic signed [A1_W-1:0] a1;
    logic signed [B1_W-1:0] b1;
    logic signed [P1_W-1:0] n_s1_prod;
    logic signed [P1_W-1:0] r_s1_prod;
    logic                   r_s1_kind;
    logic signed [31:0]     r_s1_pos, r_s1_prev, r_s1_vel;

    logic signed [P1_W-1:0] rs1;
    logic signed [63:0]     sum2;
    logic signed [31:0]     n_s2_v, r_s2_v;
    logic                   r_s2_kind;
    logic signed [31:0]     r_s2_pos, r_s2_prev, r_s2_vel;

    logic [MB_W-1:0]        b3u;
    logic signed [B3_W-1:0] b3;
    logic signed [P3_W-1:0] n_s3_prod, r_s3_prod;
    logic                   r_s3_kind;
    logic signed [31:0]     r_s3_pos, r_s3_prev, r_s3_vel, r_s3_v;

    logic signed [P3_W-1:0] rs3;
    logic signed [63:0]     rs3_ext;
    t_lane_res              n_res, r_res;

    // Pre phase forms g*dt, post phase forms (p - prev)*(1/dt) on the same multiplier.
    always_comb begin
        if (i_kind == KIND_POST) begin
            a1 = {i_pos[31], i_pos} - {i_prev[31], i_prev};
            b1 = {1'b0, i_idt};
        end else begin
            a1 = {i_grav[31], i_grav};
            b1 = {{(B1_W - DT_W){1'b0}}, i_dt};
        end
        n_s1_prod = a1 * b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_s1_prod <= n_s1_prod;
            r_s1_kind <= i_kind;
            r_s1_pos  <= i_pos;
            r_s1_prev <= i_prev;
            r_s1_vel  <= i_vel;
        end
    end

    // Rounding to nearest with ties upward is an arithmetic shift of x plus half.
    always_comb begin
        rs1 = (r_s1_prod + HALF1) >>> FRACTION_BITS;
        sum2 = {{(64 - P1_W){rs1[P1_W-1]}}, rs1};
        if (r_s1_kind == KIND_PRE) begin
            sum2 = sum2 + {{32{r_s1_vel[31]}}, r_s1_vel};
        end
        n_s2_v = sat32(sum2);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_s2_v    <= n_s2_v;
            r_s2_kind <= r_s1_kind;
            r_s2_pos  <= r_s1_pos;
            r_s2_prev <= r_s1_prev;
            r_s2_vel  <= r_s1_vel;
        end
    end

    // Pre phase scales the new velocity by dt, post phase by the damping factor.
    always_comb begin
        if (r_s2_kind == KIND_POST) begin
            b3u = MB_W'(i_factor);
        end else begin
            b3u = MB_W'(i_dt);
        end
        b3 = {1'b0, b3u};
        n_s3_prod = r_s2_v * b3;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_s3_prod <= n_s3_prod;
            r_s3_kind <= r_s2_kind;
            r_s3_pos  <= r_s2_pos;
            r_s3_prev <= r_s2_prev;
            r_s3_vel  <= r_s2_vel;
            r_s3_v    <= r_s2_v;
        end
    end

    always_comb begin
        rs3 = (r_s3_prod + HALF3) >>> FRACTION_BITS;
        rs3_ext = {{(64 - P3_W){rs3[P3_W-1]}}, rs3};
        n_res.pos  = r_s3_pos;
        n_res.prev = r_s3_prev;
        n_res.vel  = r_s3_vel;
        if (r_s3_kind == KIND_POST) begin
            n_res.calc_pos = r_s3_pos;
            n_res.calc_vel = sat32({{32{r_s3_v[31]}}, r_s3_v} - rs3_ext);
        end else begin
            n_res.calc_pos = sat32({{32{r_s3_pos[31]}}, r_s3_pos} + rs3_ext);
            n_res.calc_vel = r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/pei_damp_factor.sv
// Damping factor min(1, round(rate * inverse mass)), shared by all three lanes.
// Depends on pei_pkg.
module pei_damp_factor import pei_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  t_stage_ctl             i_ctl,
    input  logic [DATA_W-1:0]      i_rate,
    input  logic [DATA_W-1:0]      i_imass,
    output logic [FRACTION_BITS:0] o_factor
);

    localparam int PW = 2 * DATA_W;
    localparam logic [PW:0]            HALF = (PW + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic [PW:0]            ONE_W = (PW + 1)'(1) << FRACTION_BITS;
    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

    logic [PW-1:0]          r_prod;
    logic [PW:0]            q;
    logic [FRACTION_BITS:0] n_factor, r_factor;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_prod <= i_rate * i_imass;
        end
    end

    // A 32x32 product always leaves room for the rounding add in 65 bits.
    always_comb begin
        q = ({1'b0, r_prod} + HALF) >> FRACTION_BITS;
        if (q > ONE_W) begin
            n_factor = ONE;
        end else begin
            n_factor = q[FRACTION_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_factor <= n_factor;
        end
    end

    assign o_factor = r_factor;

endmodule

FILE: rtl/pei_merge.sv
// Merge stage: ground contact from the height lane, fixed-particle bypass, output register.
// Depends on pei_pkg.
module pei_merge import pei_pkg::*; (
    input  logic      i_clk,
    input  logic      i_load,
    input  logic      i_kind,
    input  logic      i_fixed,
    input  t_lane_res i_lane [AXES],
    output t_out_item o_item
);

    t_out_item n_item, r_item;
    logic      ground;

    always_comb begin
        // A negative new height drops the whole move and pins the height to zero.
        ground = i_lane[2].calc_pos[31];
        n_item.new_position_x = i_lane[0].pos;
        n_item.new_position_y = i_lane[1].pos;
        n_item.new_position_z = i_lane[2].pos;
        n_item.new_previous_x = i_lane[0].prev;
        n_item.new_previous_y = i_lane[1].prev;
        n_item.new_previous_z = i_lane[2].prev;
        n_item.new_velocity_x = i_lane[0].vel;
        n_item.new_velocity_y = i_lane[1].vel;
        n_item.new_velocity_z = i_lane[2].vel;
        if (!i_fixed) begin
            n_item.new_velocity_x = i_lane[0].calc_vel;
            n_item.new_velocity_y = i_lane[1].calc_vel;
            n_item.new_velocity_z = i_lane[2].calc_vel;
            if (i_kind == KIND_PRE) begin
                n_item.new_previous_x = i_lane[0].pos;
                n_item.new_previous_y = i_lane[1].pos;
                n_item.new_previous_z = i_lane[2].pos;
                if (ground) begin
                    n_item.new_position_z = '0;
                end else begin
                    n_item.new_position_x = i_lane[0].calc_pos;
                    n_item.new_position_y = i_lane[1].calc_pos;
                    n_item.new_position_z = i_lane[2].calc_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

FILE: rtl/particle_euler_integrate_damp.sv
// Top level of the particle integrator: configuration registers, stage control,
// three axis lanes, the damping factor unit and the merge stage. Depends on pei_pkg.
//
//   channel  | signals                                | beat
//   ---------+----------------------------------------+-------------------------
//   input    | i_in_valid / o_in_ready / i_in_item    | one particle
//   output   | o_out_valid / i_out_ready / o_out_item | one updated particle
//   config   | i_cfg_wr_en / i_cfg_index / i_cfg_wdata | one register write
//
// One beat per cycle sustained while the output is not stalled.
// Six registered stages: input, multiply, round/add, multiply, round/add, merge.
// Each stage loads when it is empty or its successor loads, so bubbles close up under
// output stalls and o_in_ready falls only when every stage holds a beat.
// Synchronous active-low reset clears the stage valid bits and loads the configuration reset values.
module particle_euler_integrate_damp import pei_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_wdata
);

    localparam int STAGES = 6;

    logic [DT_W-1:0]          r_time_step;
    logic [IDT_W-1:0]         r_inv_step;
    logic signed [DATA_W-1:0] r_grav [AXES];
    logic [DATA_W-1:0]        r_damp_rate;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] en;
    t_stage_ctl        ctl;

    t_in_item           r_s0;
    logic [4:1]         r_kind;
    logic [4:1]         r_fixed;
    logic signed [31:0] s0_pos  [AXES];
    logic signed [31:0] s0_prev [AXES];
    logic signed [31:0] s0_vel  [AXES];
    logic [FRACTION_BITS:0] factor;
    t_lane_res          lane_res [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_inv_step  <= INV_STEP_RST;
            r_grav[0]   <= GRAV_X_RST;
            r_grav[1]   <= GRAV_Y_RST;
            r_grav[2]   <= GRAV_Z_RST;
            r_damp_rate <= DAMP_RATE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_TIME_STEP:     r_time_step <= i_cfg_wdata[DT_W-1:0];
                REG_INV_TIME_STEP: r_inv_step  <= i_cfg_wdata[IDT_W-1:0];
                REG_GRAVITY_X:     r_grav[0]   <= i_cfg_wdata;
                REG_GRAVITY_Y:     r_grav[1]   <= i_cfg_wdata;
                REG_GRAVITY_Z:     r_grav[2]   <= i_cfg_wdata;
                REG_DAMPING_RATE:  r_damp_rate <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Load enables ripple back from the output register.
    always_comb begin
        en[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        ctl.en1 = en[1];
        ctl.en2 = en[2];
        ctl.en3 = en[3];
        ctl.en4 = en[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= i_in_item;
        end
        if (en[1]) begin
            r_kind[1]  <= r_s0.kind;
            r_fixed[1] <= (r_s0.inverse_mass == '0);
        end
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                r_kind[k]  <= r_kind[k-1];
                r_fixed[k] <= r_fixed[k-1];
            end
        end
    end

    assign s0_pos[0]  = r_s0.position_x;
    assign s0_pos[1]  = r_s0.position_y;
    assign s0_pos[2]  = r_s0.position_z;
    assign s0_prev[0] = r_s0.previous_x;
    assign s0_prev[1] = r_s0.previous_y;
    assign s0_prev[2] = r_s0.previous_z;
    assign s0_vel[0]  = r_s0.velocity_x;
    assign s0_vel[1]  = r_s0.velocity_y;
    assign s0_vel[2]  = r_s0.velocity_z;

    pei_damp_factor #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_factor (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_rate   (r_damp_rate),
        .i_imass  (r_s0.inverse_mass),
        .o_factor (factor)
    );

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        pei_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_kind   (r_s0.kind),
            .i_pos    (s0_pos[g]),
            .i_prev   (s0_prev[g]),
            .i_vel    (s0_vel[g]),
            .i_grav   (r_grav[g]),
            .i_dt     (r_time_step),
            .i_idt    (r_inv_step),
            .i_factor (factor),
            .o_res    (lane_res[g])
        );
    end

    pei_merge u_merge (
        .i_clk   (i_clk),
        .i_load  (en[5]),
        .i_kind  (r_kind[4]),
        .i_fixed (r_fixed[4]),
        .i_lane  (lane_res),
        .o_item  (o_out_item)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[STAGES-1];

endmodule

FILE: rtl/pei_checker.sv
// Port-level checks on the particle integrator, bound to the top level.
// Depends on pei_pkg and particle_euler_integrate_damp_defines.svh.
`include "particle_euler_integrate_damp_defines.svh"

module pei_checker import pei_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic       acc_ok;
    logic       flow;
    logic [4:0] r_flow_hist;

    assign acc_ok = i_rst_n && i_in_valid && o_in_ready;
    assign flow   = i_rst_n && i_out_ready;

    // Sink readiness history in five bits, newest in bit 0.
    always_ff @(posedge i_clk) begin
        r_flow_hist <= {r_flow_hist[3:0], flow};
    end

    // A waiting output beat holds its value.
    `PEI_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // Input back-pressure only ever comes from a stalled output beat.
    `PEI_ASSERT_IMP(a_ready_cause, !o_in_ready, o_out_valid && !i_out_ready)

    // With the sink ready throughout, an accepted beat reaches the output without stalling.
    `PEI_ASSERT_IMP(a_latency, $past(acc_ok, 6) && (&r_flow_hist), o_out_valid)

    // Nothing is offered right after reset.
    `PEI_ASSERT_IMP(a_reset_empty, $rose(i_rst_n), !o_out_valid)

endmodule

bind particle_euler_integrate_damp pei_checker u_pei_checker (.*);
